// ===== rtl/core/lskt_pkg.sv =====
`timescale 1ns / 1ps
package lskt_pkg;

  localparam int CAPACITY_DEF     = 64;
  localparam int KEY_BITS_DEF     = 32;
  localparam int PAYLOAD_BITS_DEF = 32;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_ERASE  = 2'd1,
    OP_QUERY  = 2'd2,
    OP_RESORT = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_POP,
    S_ADD,
    S_MID,
    S_PROBE,
    S_SKIP,
    S_HIT,
    S_RDP,
    S_SORT,
    S_TRIM,
    S_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic kill;
    logic pair_en;
  } cell_ctl_t;

endpackage

// ===== rtl/core/lskt_ram.sv =====
`timescale 1ns / 1ps
module lskt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/lskt_cell.sv =====
`timescale 1ns / 1ps
module lskt_cell #(
  parameter int KEY_BITS = 32,
  parameter int IDX_BITS = 6
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  lskt_pkg::cell_ctl_t   ctl,
  input  logic [KEY_BITS-1:0]   ld_key,
  input  logic [IDX_BITS-1:0]   ld_slot,
  input  logic [KEY_BITS-1:0]   left_key,
  input  logic [IDX_BITS-1:0]   left_slot,
  input  logic                  left_live,
  input  logic                  take_left,
  input  logic [KEY_BITS-1:0]   right_key,
  input  logic [IDX_BITS-1:0]   right_slot,
  input  logic                  right_live,
  output logic                  swap_right,
  output logic [KEY_BITS-1:0]   key,
  output logic [IDX_BITS-1:0]   slot,
  output logic                  live
);
  import lskt_pkg::*;

  logic [KEY_BITS-1:0] key_r;
  logic [IDX_BITS-1:0] slot_r;
  logic                live_r;
  logic                after;

  // tombstones sort last, equal keys keep their order
  always_comb begin
    if (!live_r) begin
      after = right_live;
    end else begin
      after = right_live && (key_r > right_key);
    end
  end

  assign swap_right = ctl.pair_en & after;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      live_r <= 1'b0;
    end else if (ctl.load) begin
      live_r <= 1'b1;
    end else if (ctl.kill) begin
      live_r <= 1'b0;
    end else if (swap_right) begin
      live_r <= right_live;
    end else if (take_left) begin
      live_r <= left_live;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      key_r  <= ld_key;
      slot_r <= ld_slot;
    end else if (swap_right) begin
      key_r  <= right_key;
      slot_r <= right_slot;
    end else if (take_left) begin
      key_r  <= left_key;
      slot_r <= left_slot;
    end
  end

  assign key  = key_r;
  assign slot = slot_r;
  assign live = live_r;

endmodule

// ===== rtl/core/lazy_sorted_key_table.sv =====
`timescale 1ns / 1ps
// lazily sorted keyed table
// in_ channel: one word per command, operation in in_tuser (add, erase, query,
// resort), key and payload in in_tdata. out_ channel: exactly one word per
// command with status in out_tuser and payload found, full flag and list
// lengths in out_tdata.
// the order list lives in a row of cells, one per position, each holding key,
// slot and live bit; resort runs odd-even exchange passes along the row.
// an add goes through the pop and add states to done, a refused add straight to
// done; erase and query search the sorted part by bisection, stepping over
// tombstones, and a query then reads the payload; resort runs the exchange
// passes and then trims trailing tombstones one at a time. a command is taken
// only in idle, and in_tready rises again in the cycle the result appears.
// after reset the table is empty and all slots are free; no clearing pass.
// when out_tready is low the result holds; one more command may be taken and
// worked on, then in_tready stays low until the output register drains.
module lazy_sorted_key_table #(
  parameter int CAPACITY     = lskt_pkg::CAPACITY_DEF,
  parameter int KEY_BITS     = lskt_pkg::KEY_BITS_DEF,
  parameter int PAYLOAD_BITS = lskt_pkg::PAYLOAD_BITS_DEF,
  localparam int CW  = $clog2(CAPACITY + 1),
  localparam int IDW = ((KEY_BITS + PAYLOAD_BITS + 7) / 8) * 8,
  localparam int ODW = ((PAYLOAD_BITS + 1 + 2 * CW + 7) / 8) * 8
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  input  logic [IDW-1:0] in_tdata,   // key, payload
  input  logic [1:0]     in_tuser,   // operation
  output logic           out_tvalid,
  input  logic           out_tready,
  output logic [ODW-1:0] out_tdata,  // found_payload, table_full, sorted_entries, listed_entries
  output logic [1:0]     out_tuser   // status
);
  import lskt_pkg::*;

  localparam int IW = $clog2(CAPACITY);

  state_t state_r, state_nxt;

  logic [1:0]              op_r;
  logic [KEY_BITS-1:0]     key_r;
  logic [PAYLOAD_BITS-1:0] pay_r;
  logic [CW-1:0]           low_r, high_r, mid_r, probe_r, pass_r;
  logic [IW-1:0]           pos_r;
  logic [CW-1:0]           sp_r, fresh_r, listed_r, sorted_r;
  logic [1:0]              status_r;
  logic [PAYLOAD_BITS-1:0] found_r;

  logic                    out_valid_r;
  logic [1:0]              out_status_r;
  logic [PAYLOAD_BITS-1:0] out_found_r;
  logic                    out_full_r;
  logic [CW-1:0]           out_sorted_r, out_listed_r;

  logic [KEY_BITS-1:0] ck [CAPACITY];
  logic [IW-1:0]       cs [CAPACITY];
  logic                cl [CAPACITY];
  logic                csw [CAPACITY];
  cell_ctl_t           cctl [CAPACITY];

  logic          in_acc;
  logic [CW:0]   mid_sum;
  logic [CW-1:0] mid_c, probe_c;
  logic [IW-1:0] rd_idx;
  logic [KEY_BITS-1:0] rd_key;
  logic [IW-1:0] rd_slot;
  logic          rd_live, rd_eq, rd_gt;
  logic          is_full;
  logic [IW-1:0] new_slot;

  logic                    ld_en, kill_en, sort_en;
  logic                    pay_we;
  logic [IW-1:0]           pay_raddr;
  logic [PAYLOAD_BITS-1:0] pay_rdata;
  logic                    stk_we;
  logic [IW-1:0]           stk_rdata;

  assign in_acc  = in_tvalid && in_tready;
  assign mid_sum = {1'b0, low_r} + {1'b0, high_r};
  assign mid_c   = mid_sum[CW:1];
  assign probe_c = probe_r - CW'(1);
  assign is_full = (sp_r == '0) && (fresh_r == '0);
  assign new_slot = (sp_r != '0) ? stk_rdata : IW'(fresh_r - CW'(1));

  always_comb begin
    case (state_r)
      S_MID:   rd_idx = mid_c[IW-1:0];
      S_PROBE: rd_idx = probe_c[IW-1:0];
      S_SKIP:  rd_idx = low_r[IW-1:0];
      S_TRIM:  rd_idx = IW'(listed_r - CW'(1));
      default: rd_idx = pos_r;
    endcase
  end

  assign rd_key  = ck[rd_idx];
  assign rd_slot = cs[rd_idx];
  assign rd_live = cl[rd_idx];
  assign rd_eq   = rd_key == key_r;
  assign rd_gt   = rd_key > key_r;

  genvar g;
  generate
    for (g = 0; g < CAPACITY; g++) begin : g_cell
      always_comb begin
        cctl[g].load    = ld_en && (listed_r[IW-1:0] == IW'(g));
        cctl[g].kill    = kill_en && (pos_r == IW'(g));
        cctl[g].pair_en = sort_en && (pass_r[0] == 1'(g % 2)) &&
                          (g < CAPACITY - 1) && (CW'(g + 1) < listed_r);
      end

      lskt_cell #(
        .KEY_BITS (KEY_BITS),
        .IDX_BITS (IW)
      ) u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (cctl[g]),
        .ld_key     (key_r),
        .ld_slot    (new_slot),
        .left_key   ((g > 0) ? ck[(g > 0) ? g - 1 : 0] : '0),
        .left_slot  ((g > 0) ? cs[(g > 0) ? g - 1 : 0] : '0),
        .left_live  ((g > 0) ? cl[(g > 0) ? g - 1 : 0] : 1'b0),
        .take_left  ((g > 0) ? csw[(g > 0) ? g - 1 : 0] : 1'b0),
        .right_key  ((g < CAPACITY - 1) ? ck[(g < CAPACITY - 1) ? g + 1 : g] : '0),
        .right_slot ((g < CAPACITY - 1) ? cs[(g < CAPACITY - 1) ? g + 1 : g] : '0),
        .right_live ((g < CAPACITY - 1) ? cl[(g < CAPACITY - 1) ? g + 1 : g] : 1'b0),
        .swap_right (csw[g]),
        .key        (ck[g]),
        .slot       (cs[g]),
        .live       (cl[g])
      );
    end
  endgenerate

  lskt_ram #(
    .WIDTH (PAYLOAD_BITS),
    .DEPTH (CAPACITY)
  ) u_pay_ram (
    .clk   (clk),
    .we    (pay_we),
    .waddr (new_slot),
    .wdata (pay_r),
    .raddr (pay_raddr),
    .rdata (pay_rdata)
  );

  // stack of freed slots, topped over the never used slots
  lskt_ram #(
    .WIDTH (IW),
    .DEPTH (CAPACITY)
  ) u_free_ram (
    .clk   (clk),
    .we    (stk_we),
    .waddr (sp_r[IW-1:0]),
    .wdata (rd_slot),
    .raddr (IW'(sp_r - CW'(1))),
    .rdata (stk_rdata)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          case (op_t'(in_tuser))
            OP_ADD: begin
              if ((listed_r == CW'(CAPACITY)) || is_full) begin
                state_nxt = S_DONE;
              end else begin
                state_nxt = S_POP;
              end
            end
            OP_RESORT: state_nxt = S_SORT;
            default:   state_nxt = S_MID;
          endcase
        end
      end
      S_POP: state_nxt = S_ADD;
      S_ADD: state_nxt = S_DONE;
      S_MID: begin
        if (low_r >= high_r) begin
          state_nxt = S_DONE;
        end else if (rd_live && rd_eq) begin
          state_nxt = S_HIT;
        end else if (!rd_live) begin
          state_nxt = S_PROBE;
        end
      end
      S_PROBE: begin
        if (probe_r > low_r) begin
          if (rd_live && rd_eq) begin
            state_nxt = S_HIT;
          end else if (rd_live && rd_gt) begin
            state_nxt = S_MID;
          end
        end else begin
          state_nxt = S_SKIP;
        end
      end
      S_SKIP: begin
        if (!((low_r < high_r) && !rd_live)) begin
          state_nxt = S_MID;
        end
      end
      S_HIT: begin
        if (op_t'(op_r) == OP_QUERY) begin
          state_nxt = S_RDP;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_RDP: state_nxt = S_DONE;
      S_SORT: begin
        if (pass_r == CW'(CAPACITY - 1)) begin
          state_nxt = S_TRIM;
        end
      end
      S_TRIM: begin
        if (!((listed_r != '0) && !rd_live)) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_tready = (state_r == S_IDLE);
    ld_en     = (state_r == S_ADD);
    pay_we    = (state_r == S_ADD);
    kill_en   = (state_r == S_HIT) && (op_t'(op_r) == OP_ERASE);
    stk_we    = kill_en;
    sort_en   = (state_r == S_SORT);
    pay_raddr = rd_slot;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      sp_r        <= '0;
      fresh_r     <= CW'(CAPACITY);
      listed_r    <= '0;
      sorted_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if ((state_r == S_DONE) && (!out_valid_r || out_tready)) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_ADD: begin
          listed_r <= listed_r + CW'(1);
          if (sp_r != '0) begin
            sp_r <= sp_r - CW'(1);
          end else begin
            fresh_r <= fresh_r - CW'(1);
          end
        end
        S_HIT: begin
          if (kill_en) begin
            sp_r <= sp_r + CW'(1);
          end
        end
        S_TRIM: begin
          if ((listed_r != '0) && !rd_live) begin
            listed_r <= listed_r - CW'(1);
          end else begin
            sorted_r <= listed_r;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          op_r     <= in_tuser;
          key_r    <= in_tdata[KEY_BITS-1:0];
          pay_r    <= in_tdata[KEY_BITS +: PAYLOAD_BITS];
          low_r    <= '0;
          high_r   <= sorted_r;
          pass_r   <= '0;
          found_r  <= '0;
          status_r <= ((op_t'(in_tuser) == OP_ADD) &&
                       ((listed_r == CW'(CAPACITY)) || is_full)) ? ST_FULL : ST_DONE;
        end
      end
      S_MID: begin
        mid_r   <= mid_c;
        probe_r <= mid_c;
        if (low_r >= high_r) begin
          status_r <= ST_NOT_FOUND;
        end else if (rd_live) begin
          if (rd_eq) begin
            pos_r <= mid_c[IW-1:0];
          end else if (rd_gt) begin
            high_r <= mid_c;
          end else begin
            low_r <= mid_c + CW'(1);
          end
        end
      end
      S_PROBE: begin
        if (probe_r > low_r) begin
          probe_r <= probe_c;
          if (rd_live && rd_eq) begin
            pos_r <= probe_c[IW-1:0];
          end else if (rd_live && rd_gt) begin
            high_r <= probe_c;
          end
        end else begin
          low_r <= mid_r + CW'(1);
        end
      end
      S_SKIP: begin
        if ((low_r < high_r) && !rd_live) begin
          low_r <= low_r + CW'(1);
        end
      end
      S_RDP:  found_r <= pay_rdata;
      S_SORT: pass_r  <= pass_r + CW'(1);
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_status_r <= status_r;
          out_found_r  <= found_r;
          out_full_r   <= is_full;
          out_sorted_r <= sorted_r;
          out_listed_r <= listed_r;
        end
      end
      default: ;
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = ODW'({out_listed_r, out_sorted_r, out_full_r, out_found_r});

endmodule
